### rtl/lru_key_value_cache_defines.svh
// ----------------------------------------------------------------------------
// lru key value cache assertion macros
// clocked assertion helpers used by lru_key_value_cache
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define LKVC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define LKVC_ASSERT_IMPL(label, ante, cons, msg) \
  `LKVC_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
  `LKVC_ASSERT(label, (ante) |=> (cons), msg)

`endif

### rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants of the lru key value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int DEFAULT_ENTRIES = 16;
  localparam int DATA_W          = 32;
  localparam int CAP_W           = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] lookup_key;
    logic signed [DATA_W-1:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
  } out_word_t;

  typedef struct packed {
    logic hit;
    logic free_any;
  } lkvc_status_t;

endpackage

### rtl/lkvc_lookup.sv
// ----------------------------------------------------------------------------
// lkvc_lookup
// parallel key match, lru victim and free slot selection, all one-hot
// ----------------------------------------------------------------------------
module lkvc_lookup #(
  parameter int  ENTRIES = lkvc_pkg::DEFAULT_ENTRIES,
  localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
  input  logic [ENTRIES-1:0]                       valid,
  input  logic [ENTRIES-1:0][lkvc_pkg::DATA_W-1:0] keys,
  input  logic [ENTRIES-1:0][RANK_W-1:0]           ranks,
  input  logic [lkvc_pkg::DATA_W-1:0]              key,
  input  logic [CNT_W-1:0]                         used,
  output logic [ENTRIES-1:0]                       match_oh,
  output logic [ENTRIES-1:0]                       victim_oh,
  output logic [ENTRIES-1:0]                       free_oh,
  output logic [RANK_W-1:0]                        match_rank,
  output lkvc_pkg::lkvc_status_t                   status
);
  import lkvc_pkg::*;

  logic [ENTRIES-1:0] match_raw;
  logic [ENTRIES-1:0] victim_raw;
  logic [ENTRIES-1:0] free_raw;
  logic [CNT_W-1:0]   used_m1;

  assign used_m1 = used - 1'b1;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_raw[i]  = valid[i] && (keys[i] == key);
      victim_raw[i] = valid[i] && (ranks[i] == used_m1[RANK_W-1:0]);
      free_raw[i]   = !valid[i];
    end
  end

  // lowest set bit wins
  assign match_oh  = match_raw & (~match_raw + 1'b1);
  assign victim_oh = victim_raw & (~victim_raw + 1'b1);
  assign free_oh   = free_raw & (~free_raw + 1'b1);

  always_comb begin
    match_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_rank = match_rank | (ranks[i] & {RANK_W{match_oh[i]}});
    end
  end

  assign status.hit      = |match_raw;
  assign status.free_any = |free_raw;

endmodule

### rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key/value cache with least-recently-used replacement.
// in_data carries a get or put word; in_valid/in_ready accept it. each
// accepted word yields exactly one out_data word on out_valid/out_ready.
// a word accepted into the input register moves on to the output register and
// is presented on out_valid. one word per cycle while out_ready does not stall,
// with key compare and recency rank update combinational between the registers.
// a stalled out_ready holds the result in the output register; the input
// register then fills and in_ready drops until the result is taken.
// cfg_wr_en/cfg_wr_data write the capacity in use (0 acts as 1, values above
// the entry count act as the entry count); write only while idle.
// reset empties the cache at once (valid bits cleared, count zero) and sets
// the capacity to 16; the first word can be taken right after reset.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache #(
  parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lkvc_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lkvc_pkg::out_word_t        out_data,
  input  logic                       cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data
);
  import lkvc_pkg::*;

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0]                 cap_r;
  logic                             s1_valid_r;
  in_word_t                         s1_word_r;
  logic                             out_valid_r;
  out_word_t                        out_word_r;
  out_word_t                        result;

  logic [ENTRIES-1:0]               valid_r, valid_nxt;
  logic [ENTRIES-1:0][DATA_W-1:0]   key_r;
  logic [ENTRIES-1:0][DATA_W-1:0]   value_r;
  logic [ENTRIES-1:0][RANK_W-1:0]   rank_r, rank_nxt;
  logic [CNT_W-1:0]                 used_r, used_nxt;

  logic                             advance;
  logic                             in_fire;
  logic                             is_put;
  logic                             need_evict;
  logic                             insert;
  logic [CMP_W-1:0]                 cap_ext;
  logic [CMP_W-1:0]                 cap_eff;
  logic [ENTRIES-1:0]               match_oh;
  logic [ENTRIES-1:0]               victim_oh;
  logic [ENTRIES-1:0]               free_oh;
  logic [ENTRIES-1:0]               slot_oh;
  logic [ENTRIES-1:0]               wr_oh;
  logic [RANK_W-1:0]                match_rank;
  logic [DATA_W-1:0]                hit_value;
  lkvc_status_t                     status;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= in_data;
    end
  end

  lkvc_lookup #(
    .ENTRIES (ENTRIES)
  ) u_lookup (
    .valid      (valid_r),
    .keys       (key_r),
    .ranks      (rank_r),
    .key        (s1_word_r.lookup_key),
    .used       (used_r),
    .match_oh   (match_oh),
    .victim_oh  (victim_oh),
    .free_oh    (free_oh),
    .match_rank (match_rank),
    .status     (status)
  );

  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign is_put     = (s1_word_r.cmd == CMD_PUT);
  assign need_evict = is_put && !status.hit && (CMP_W'(used_r) >= cap_eff);
  assign insert     = is_put && !status.hit && (need_evict || status.free_any);
  assign slot_oh    = need_evict ? victim_oh : free_oh;
  assign wr_oh      = !advance ? '0 :
                      (is_put && status.hit) ? match_oh :
                      insert ? slot_oh : '0;

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (value_r[i] & {DATA_W{match_oh[i]}});
    end
  end

  always_comb begin
    result.hit     = status.hit;
    result.evicted = need_evict;
    if (is_put) begin
      result.read_value = PUT_VALUE;
    end else if (status.hit) begin
      result.read_value = hit_value;
    end else begin
      result.read_value = MISS_VALUE;
    end
  end

  // recency ranks: 0 is most recent
  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    used_nxt  = used_r;
    if (advance) begin
      if (status.hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (match_oh[i]) begin
            rank_nxt[i] = '0;
          end else if (valid_r[i] && (rank_r[i] < match_rank)) begin
            rank_nxt[i] = rank_r[i] + 1'b1;
          end
        end
      end else if (insert) begin
        valid_nxt = valid_r | slot_oh;
        if (!need_evict) begin
          used_nxt = used_r + 1'b1;
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_oh[i]) begin
            rank_nxt[i] = '0;
          end else if (valid_r[i]) begin
            rank_nxt[i] = rank_r[i] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rank_r  <= '0;
      used_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      used_r  <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_oh[i]) begin
        key_r[i]   <= s1_word_r.lookup_key;
        value_r[i] <= s1_word_r.write_value;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= result;
    end
  end

  `LKVC_ASSERT(a_used_matches_valid, used_r == $countones(valid_r), "entry count out of step")
  `LKVC_ASSERT_IMPL(a_hit_no_evict, out_valid_r, !(out_word_r.hit && out_word_r.evicted),
    "eviction on a hit")
  `LKVC_ASSERT_NEXT(a_get_keeps_valid, advance && !is_put, $stable(valid_r) && $stable(used_r),
    "get changed the entry set")
  `LKVC_ASSERT_NEXT(a_fill_counts, advance && insert && !need_evict,
    used_r == $past(used_r) + 1'b1, "fill did not grow the count")

endmodule
